### rtl/core/vtb_pkg.sv
package vtb_pkg;

  localparam int MATCH_ENTRIES_DEF = 16;
  localparam int MAX_EXTENT_DEF    = 1024;

  localparam int DATA_W  = 32;
  localparam int IDX_W   = 10;
  localparam int SLOT_W  = 4;
  localparam int MODE_W  = 9;
  localparam int LAST_W  = 30;
  localparam int COUNT_W = 5;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_THR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INSIDE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUTSIDE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_IDX   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_CNT  = 3'd7;

  // Mode flag bit positions.
  localparam int FLAG_LOW   = 0;
  localparam int FLAG_HIGH  = 1;
  localparam int FLAG_MATCH = 2;
  localparam int FLAG_MASK  = 3;
  localparam int FLAG_MERGE = 4;
  localparam int FLAG_ECOL  = 5;
  localparam int FLAG_EROW  = 6;
  localparam int FLAG_ESLC  = 7;
  localparam int FLAG_ABS   = 8;

  // Request types.
  localparam logic REQ_VOXEL = 1'b0;
  localparam logic REQ_LOAD  = 1'b1;

  // Reset values.
  localparam logic signed [DATA_W-1:0] MASK_THR_RST = 32'sd32768;
  localparam logic signed [DATA_W-1:0] INSIDE_RST   = 32'sd1;

  typedef struct packed {
    logic signed [DATA_W-1:0] low_thr;
    logic signed [DATA_W-1:0] high_thr;
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] mask_thr;
    logic signed [DATA_W-1:0] inside_val;
    logic signed [DATA_W-1:0] outside_val;
    logic [LAST_W-1:0]        last_idx;
    logic [COUNT_W-1:0]       match_cnt;
  } cfg_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] value;
  } class_res_t;

endpackage

### rtl/core/vtb_cfg_regs.sv
module vtb_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [vtb_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [vtb_pkg::DATA_W-1:0]    wr_data,
  output vtb_pkg::cfg_t                 cfg
);
  import vtb_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_thr     <= '0;
      cfg.high_thr    <= '0;
      cfg.mode        <= '0;
      cfg.mask_thr    <= MASK_THR_RST;
      cfg.inside_val  <= INSIDE_RST;
      cfg.outside_val <= '0;
      cfg.last_idx    <= '0;
      cfg.match_cnt   <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_LOW_THR:   cfg.low_thr     <= wr_data;
        REG_HIGH_THR:  cfg.high_thr    <= wr_data;
        REG_MODE:      cfg.mode        <= wr_data[MODE_W-1:0];
        REG_MASK_THR:  cfg.mask_thr    <= wr_data;
        REG_INSIDE:    cfg.inside_val  <= wr_data;
        REG_OUTSIDE:   cfg.outside_val <= wr_data;
        REG_LAST_IDX:  cfg.last_idx    <= wr_data[LAST_W-1:0];
        REG_MATCH_CNT: cfg.match_cnt   <= wr_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/vtb_label_table.sv
module vtb_label_table #(
  parameter int MATCH_ENTRIES = vtb_pkg::MATCH_ENTRIES_DEF
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [vtb_pkg::SLOT_W-1:0]                 wr_slot,
  input  logic [vtb_pkg::DATA_W-1:0]                 wr_label,
  output logic [MATCH_ENTRIES-1:0][vtb_pkg::DATA_W-1:0] labels
);
  import vtb_pkg::*;

  // Every entry feeds its own comparator, so the table is a row of registers.
  // Slots at or above the table depth never match and are dropped.
  always_ff @(posedge clk) begin
    for (int k = 0; k < MATCH_ENTRIES; k++) begin
      if (wr_en && (32'(wr_slot) == 32'(k))) begin
        labels[k] <= wr_label;
      end
    end
  end

endmodule

### rtl/core/vtb_classify.sv
module vtb_classify #(
  parameter int MATCH_ENTRIES = vtb_pkg::MATCH_ENTRIES_DEF,
  parameter int MAX_EXTENT    = vtb_pkg::MAX_EXTENT_DEF
) (
  input  vtb_pkg::cfg_t                                 cfg,
  input  logic signed [vtb_pkg::DATA_W-1:0]             voxel_value,
  input  logic signed [vtb_pkg::DATA_W-1:0]             mask_value,
  input  logic signed [vtb_pkg::DATA_W-1:0]             merge_value,
  input  logic [vtb_pkg::IDX_W-1:0]                     col_index,
  input  logic [vtb_pkg::IDX_W-1:0]                     row_index,
  input  logic [vtb_pkg::IDX_W-1:0]                     slice_index,
  input  logic [MATCH_ENTRIES-1:0][vtb_pkg::DATA_W-1:0] labels,
  output vtb_pkg::class_res_t                           res
);
  import vtb_pkg::*;

  localparam int IDX_SPAN = 1 << IDX_W;
  localparam int LAST_CAP = (MAX_EXTENT > IDX_SPAN) ? (IDX_SPAN - 1) : (MAX_EXTENT - 1);

  function automatic logic [IDX_W-1:0] clamp_last(input logic [IDX_W-1:0] last);
    logic [IDX_W-1:0] cap;
    cap = IDX_W'(LAST_CAP);
    return (last > cap) ? cap : last;
  endfunction

  function automatic logic on_edge(input logic [IDX_W-1:0] idx,
                                   input logic [IDX_W-1:0] last);
    return (idx == '0) || (idx == clamp_last(last));
  endfunction

  logic signed [DATA_W-1:0] miss_val;
  logic signed [DATA_W-1:0] val;
  logic                     excluded;
  logic                     matched;
  logic                     out_of_range;
  logic                     hit;

  always_comb begin
    miss_val = cfg.mode[FLAG_MERGE] ? merge_value : cfg.outside_val;

    excluded = (cfg.mode[FLAG_ECOL] && on_edge(col_index, cfg.last_idx[IDX_W-1:0])) ||
               (cfg.mode[FLAG_EROW] && on_edge(row_index, cfg.last_idx[2*IDX_W-1:IDX_W])) ||
               (cfg.mode[FLAG_ESLC] &&
                on_edge(slice_index, cfg.last_idx[3*IDX_W-1:2*IDX_W])) ||
               (cfg.mode[FLAG_MASK] && (mask_value < cfg.mask_thr));

    // Absolute value saturates the most negative code.
    val = voxel_value;
    if (cfg.mode[FLAG_ABS] && voxel_value[DATA_W-1]) begin
      if (voxel_value == {1'b1, {(DATA_W-1){1'b0}}}) begin
        val = {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
        val = -voxel_value;
      end
    end

    // A label matches when the voxel equals it shifted into Q16.16, which
    // requires the label to fit 16 signed bits and the fraction to be zero.
    matched = 1'b0;
    for (int k = 0; k < MATCH_ENTRIES; k++) begin
      if ((32'(k) < 32'(cfg.match_cnt)) &&
          ((&labels[k][DATA_W-1:15]) || !(|labels[k][DATA_W-1:15])) &&
          (val[15:0] == 16'd0) && (val[DATA_W-1:16] == labels[k][15:0])) begin
        matched = 1'b1;
      end
    end

    out_of_range = (cfg.mode[FLAG_LOW] && (val < cfg.low_thr)) ||
                   (cfg.mode[FLAG_HIGH] && (val > cfg.high_thr));

    hit = !excluded && (cfg.mode[FLAG_MATCH] ? matched : !out_of_range);

    res.hit   = hit;
    res.value = hit ? cfg.inside_val : miss_val;
  end

endmodule

### rtl/core/voxel_threshold_binarizer_top.sv
// Voxel threshold binarizer. One item enters per cycle unless the input stalls;
// a voxel is registered in the input register, classified by a single pass of
// compare logic (edge, mask, range or a parallel compare against the first
// match_cnt label table entries), and written to the result register, which
// also carries the running hit count. Load items write one label table entry
// and give no result; they take effect for every voxel that follows them.
// The input side keeps taking items while a finished result waits, and stops
// only when the result register is held and the input register holds a voxel.
// Configuration writes are taken every cycle; there is no clearing pass after
// reset, and label entries read before they are loaded give arbitrary results.
module voxel_threshold_binarizer_top #(
  parameter int MATCH_ENTRIES = vtb_pkg::MATCH_ENTRIES_DEF,
  parameter int MAX_EXTENT    = vtb_pkg::MAX_EXTENT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              req_type,
  input  logic signed [vtb_pkg::DATA_W-1:0] voxel_value,
  input  logic signed [vtb_pkg::DATA_W-1:0] mask_value,
  input  logic signed [vtb_pkg::DATA_W-1:0] merge_value,
  input  logic [vtb_pkg::IDX_W-1:0]         col_index,
  input  logic [vtb_pkg::IDX_W-1:0]         row_index,
  input  logic [vtb_pkg::IDX_W-1:0]         slice_index,
  input  logic [vtb_pkg::SLOT_W-1:0]        entry_slot,
  input  logic signed [vtb_pkg::DATA_W-1:0] entry_label,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [vtb_pkg::DATA_W-1:0] result_value,
  output logic                              is_hit,
  output logic [vtb_pkg::DATA_W-1:0]        hits_so_far,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vtb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vtb_pkg::DATA_W-1:0]        cfg_data
);
  import vtb_pkg::*;

  cfg_t cfg;

  // Input register.
  logic                     s1_valid;
  logic                     s1_type;
  logic signed [DATA_W-1:0] s1_voxel;
  logic signed [DATA_W-1:0] s1_mask;
  logic signed [DATA_W-1:0] s1_merge;
  logic [IDX_W-1:0]         s1_col;
  logic [IDX_W-1:0]         s1_row;
  logic [IDX_W-1:0]         s1_slice;
  logic [SLOT_W-1:0]        s1_slot;
  logic [DATA_W-1:0]        s1_label;

  logic [MATCH_ENTRIES-1:0][DATA_W-1:0] labels;
  class_res_t               res;
  logic [DATA_W-1:0]        hit_count;
  logic [DATA_W-1:0]        hit_count_next;

  logic out_free;
  logic s1_go;
  logic s1_voxel_go;
  logic in_xfer;

  assign cfg_ready   = 1'b1;
  assign out_free    = !out_valid || out_ready;
  // A load item leaves the input register at once; a voxel needs room downstream.
  assign s1_go       = s1_valid && ((s1_type == REQ_LOAD) || out_free);
  assign s1_voxel_go = s1_go && (s1_type == REQ_VOXEL);
  assign in_ready    = !s1_valid || s1_go;
  assign in_xfer     = in_valid && in_ready;

  assign hit_count_next = hit_count + DATA_W'(res.hit);

  vtb_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  vtb_label_table #(
    .MATCH_ENTRIES (MATCH_ENTRIES)
  ) u_table (
    .clk      (clk),
    .wr_en    (s1_go && (s1_type == REQ_LOAD)),
    .wr_slot  (s1_slot),
    .wr_label (s1_label),
    .labels   (labels)
  );

  vtb_classify #(
    .MATCH_ENTRIES (MATCH_ENTRIES),
    .MAX_EXTENT    (MAX_EXTENT)
  ) u_classify (
    .cfg         (cfg),
    .voxel_value (s1_voxel),
    .mask_value  (s1_mask),
    .merge_value (s1_merge),
    .col_index   (s1_col),
    .row_index   (s1_row),
    .slice_index (s1_slice),
    .labels      (labels),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_type  <= req_type;
      s1_voxel <= voxel_value;
      s1_mask  <= mask_value;
      s1_merge <= merge_value;
      s1_col   <= col_index;
      s1_row   <= row_index;
      s1_slice <= slice_index;
      s1_slot  <= entry_slot;
      s1_label <= entry_label;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      hit_count <= '0;
    end else begin
      if (s1_voxel_go) begin
        out_valid <= 1'b1;
        hit_count <= hit_count_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_voxel_go) begin
      result_value <= res.value;
      is_hit       <= res.hit;
      hits_so_far  <= hit_count_next;
    end
  end

endmodule

### rtl/core/vtb_checker.sv
module vtb_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [vtb_pkg::DATA_W-1:0] result_value,
  input logic                              is_hit,
  input logic [vtb_pkg::DATA_W-1:0]        hits_so_far
);
  import vtb_pkg::*;

  logic              seen;
  logic [DATA_W-1:0] prev_hits;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen      <= 1'b0;
      prev_hits <= '0;
    end else if (out_valid && out_ready) begin
      seen      <= 1'b1;
      prev_hits <= hits_so_far;
    end
  end

  // The first result after reset counts from zero.
  a_first_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !seen) |-> (hits_so_far == DATA_W'(is_hit)))
    else $error("first hit count does not start from zero");

  // Each transferred result extends the running count by its own hit.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && seen) |-> (hits_so_far == prev_hits + DATA_W'(is_hit)))
    else $error("hit count does not follow the previous result");

  // Input is held back only while a result is waiting downstream.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a held result");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(result_value) && $stable(is_hit) && $stable(hits_so_far)))
    else $error("result changed while stalled");

endmodule

bind voxel_threshold_binarizer_top vtb_checker u_vtb_checker (.*);
